@@ src/kth_largest_select_assert.svh @@
// Assertion macros shared by the RTL of the k-th largest selector.
// They sample on i_clk and are switched off while i_rst_n is low.
`ifndef KTH_LARGEST_SELECT_ASSERT_SVH
`define KTH_LARGEST_SELECT_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define KLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked outside reset.
`define KLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kls_pkg.sv @@
package kls_pkg;

    localparam int VALUE_BITS = 32;
    localparam int K_BITS     = 7;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] kth_largest;
        logic                         enough;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_INIT,
        S_UP_CHECK,
        S_UP_CMP,
        S_UP_PLACE,
        S_DROP_TEST,
        S_DN_CHECK,
        S_DN_CMP,
        S_DN_PLACE,
        S_FINISH
    } t_step;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_UP_INIT,
        OP_UP_MOVE,
        OP_PLACE,
        OP_DN_INIT,
        OP_DN_MOVE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NOT_START,
        C_FULL,
        C_POS_ZERO,
        C_KEY_LT_RD,
        C_KEY_LE_ROOT,
        C_NO_LEFT,
        C_CHILD_LT_KEY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  rd_child;
        t_step jump;
        t_step next;
    } t_ctrl;

    function automatic t_ctrl f_ucode(input t_step step);
        t_ctrl cw;
        cw = '{OP_NONE, C_ALWAYS, 1'b0, S_IDLE, S_IDLE};
        case (step)
            S_IDLE:      cw = '{OP_ACCEPT,  C_NOT_START,    1'b0, S_IDLE,     S_DISPATCH};
            S_DISPATCH:  cw = '{OP_NONE,    C_FULL,         1'b0, S_DROP_TEST, S_UP_INIT};
            S_UP_INIT:   cw = '{OP_UP_INIT, C_ALWAYS,       1'b0, S_UP_CHECK, S_UP_CHECK};
            S_UP_CHECK:  cw = '{OP_NONE,    C_POS_ZERO,     1'b0, S_UP_PLACE, S_UP_CMP};
            S_UP_CMP:    cw = '{OP_UP_MOVE, C_KEY_LT_RD,    1'b0, S_UP_CHECK, S_UP_PLACE};
            S_UP_PLACE:  cw = '{OP_PLACE,   C_ALWAYS,       1'b0, S_FINISH,   S_FINISH};
            S_DROP_TEST: cw = '{OP_DN_INIT, C_KEY_LE_ROOT,  1'b0, S_FINISH,   S_DN_CHECK};
            S_DN_CHECK:  cw = '{OP_NONE,    C_NO_LEFT,      1'b1, S_DN_PLACE, S_DN_CMP};
            S_DN_CMP:    cw = '{OP_DN_MOVE, C_CHILD_LT_KEY, 1'b1, S_DN_CHECK, S_DN_PLACE};
            S_DN_PLACE:  cw = '{OP_PLACE,   C_ALWAYS,       1'b0, S_FINISH,   S_FINISH};
            S_FINISH:    cw = '{OP_FINISH,  C_ALWAYS,       1'b0, S_IDLE,     S_IDLE};
            default:     cw = '{OP_NONE,    C_ALWAYS,       1'b0, S_IDLE,     S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ src/kth_largest_select.sv @@
// Reports the k-th largest of a set of signed Q16.16 values, one value per beat with the
// last one marked, using a min-heap of up to MAX_RANK entries held in a two-read-port RAM.
// A beat is taken when start is high and busy is low; busy then stays high while a small
// microprogram works on it. A value that is dropped passes only DISPATCH, DROP_TEST and
// FINISH before the next possible accept, and an insertion or replacement walks the heap
// level by level; each level costs a RAM read step and a compare-and-move step.
// On the last beat the result appears on o_beat for exactly one cycle with o_strobe high,
// right after busy drops; it cannot be held off, so the receiver must take it then. The flag
// enough is low when the set held fewer than k values, and the value is then the smallest
// of the set. Writing k_rank clears the set in progress; k of 0 acts as 1 and k above
// MAX_RANK acts as MAX_RANK. No clearing pass runs after reset.
`include "kth_largest_select_assert.svh"

module kth_largest_select
    import kls_pkg::*;
#(
    parameter int MAX_RANK = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_beat          i_beat,
    input  logic              i_cfg_we,
    input  logic [K_BITS-1:0] i_cfg_wdata,
    output logic              o_strobe,
    output t_out_beat         o_beat
);

    localparam int ADDR_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W  = $clog2(MAX_RANK + 1);
    localparam int LW     = ADDR_W + 2;
    localparam int CMP_W  = (CNT_W > K_BITS) ? CNT_W : K_BITS;

    t_step                  r_step;
    t_step                  n_step;
    logic [CNT_W-1:0]       r_fill;
    logic [K_BITS-1:0]      r_k_rank;
    logic                   r_strobe;

    logic [VALUE_BITS-1:0]  r_key;
    logic                   r_last;
    logic [ADDR_W-1:0]      r_pos;
    logic [VALUE_BITS-1:0]  r_root;
    logic [VALUE_BITS-1:0]  r_rd_a;
    logic [VALUE_BITS-1:0]  r_rd_b;
    t_out_beat              r_out;
    logic [VALUE_BITS-1:0]  mem [MAX_RANK];

    t_ctrl                  cw;
    logic                   take;
    logic [CMP_W-1:0]       k_ext;
    logic [CNT_W-1:0]       k_eff;
    logic [ADDR_W-1:0]      parent;
    logic [LW-1:0]          left;
    logic [LW-1:0]          right;
    logic [LW-1:0]          fill_ext;
    logic                   sel_right;
    logic [VALUE_BITS-1:0]  child_val;
    logic [ADDR_W-1:0]      child_idx;
    logic [ADDR_W-1:0]      rd_addr_a;
    logic [ADDR_W-1:0]      rd_addr_b;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_BITS-1:0]  mem_wdata;

    always_comb begin
        k_ext = CMP_W'(r_k_rank);
        if (k_ext == '0) begin
            k_eff = CNT_W'(1);
        end else if (k_ext > CMP_W'(MAX_RANK)) begin
            k_eff = CNT_W'(MAX_RANK);
        end else begin
            k_eff = CNT_W'(k_ext);
        end
    end

    assign cw        = f_ucode(r_step);
    assign busy      = (r_step != S_IDLE);
    assign parent    = (r_pos - ADDR_W'(1)) >> 1;
    assign left      = {1'b0, r_pos, 1'b1};
    assign right     = left + LW'(1);
    assign fill_ext  = LW'(r_fill);
    assign sel_right = (right < fill_ext) && (r_rd_b < r_rd_a);
    assign child_val = sel_right ? r_rd_b : r_rd_a;
    assign child_idx = sel_right ? ADDR_W'(right) : ADDR_W'(left);
    assign rd_addr_a = cw.rd_child ? ADDR_W'(left) : parent;
    assign rd_addr_b = ADDR_W'(right);

    always_comb begin
        case (cw.cond)
            C_ALWAYS:       take = 1'b1;
            C_NOT_START:    take = !start;
            C_FULL:         take = (r_fill >= k_eff);
            C_POS_ZERO:     take = (r_pos == '0);
            C_KEY_LT_RD:    take = (r_key < r_rd_a);
            C_KEY_LE_ROOT:  take = (r_key <= r_root);
            C_NO_LEFT:      take = (left >= fill_ext);
            C_CHILD_LT_KEY: take = (child_val < r_key);
            default:        take = 1'b0;
        endcase
    end

    always_comb begin
        n_step = take ? cw.jump : cw.next;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_key;
        case (cw.op)
            OP_UP_MOVE: begin
                mem_we    = take;
                mem_wdata = r_rd_a;
            end
            OP_DN_MOVE: begin
                mem_we    = take;
                mem_wdata = child_val;
            end
            OP_PLACE: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_IDLE;
            r_fill   <= '0;
            r_k_rank <= K_BITS'(1);
            r_strobe <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_strobe <= (cw.op == OP_FINISH) && r_last;
            if (i_cfg_we) begin
                r_k_rank <= i_cfg_wdata;
                r_fill   <= '0;
            end else begin
                case (cw.op)
                    OP_UP_INIT: begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    OP_FINISH: begin
                        if (r_last) begin
                            r_fill <= '0;
                        end
                    end
                    default: begin
                        r_fill <= r_fill;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
            if (mem_waddr == '0) begin
                r_root <= mem_wdata;
            end
        end
        case (cw.op)
            OP_ACCEPT: begin
                if (start) begin
                    r_key  <= {~i_beat.value[VALUE_BITS-1], i_beat.value[VALUE_BITS-2:0]};
                    r_last <= i_beat.last;
                end
            end
            OP_UP_INIT: begin
                r_pos <= ADDR_W'(r_fill);
            end
            OP_UP_MOVE: begin
                if (take) begin
                    r_pos <= parent;
                end
            end
            OP_DN_INIT: begin
                r_pos <= '0;
            end
            OP_DN_MOVE: begin
                if (take) begin
                    r_pos <= child_idx;
                end
            end
            OP_FINISH: begin
                r_out.kth_largest <= {~r_root[VALUE_BITS-1], r_root[VALUE_BITS-2:0]};
                r_out.enough      <= (r_fill >= k_eff);
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_beat   = r_out;

    `KLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `KLS_ASSERT_NEXT(a_last_strobe, (r_step == S_FINISH) && r_last, o_strobe, "missing result")
    `KLS_ASSERT_SAME(a_strobe_idle, o_strobe, !busy, "result shown while still busy")
    `KLS_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= k_eff, "heap fill exceeds rank")

endmodule

@@ tb/tb_kth_largest_select.sv @@
module tb_kth_largest_select;
    import kls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RANK   = 64;
    localparam int TARGET     = 600;
    localparam int QUIET_WAIT = 24;
    localparam int DOG_LIMIT  = 2000;
    localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_in_beat          i_beat      = '0;
    logic              i_cfg_we    = 1'b0;
    logic [K_BITS-1:0] i_cfg_wdata = '0;
    logic              o_strobe;
    t_out_beat         o_beat;

    logic [VALUE_BITS-1:0] heap_keys [MAX_RANK];
    int                    held_count = 0;
    logic [K_BITS-1:0]     rank_k     = 1;
    t_out_beat             pending_ranks [$];
    int                    errors     = 0;
    int                    sent       = 0;
    int                    idle_count = 0;
    bit                    burst_mode = 1'b0;

    kth_largest_select #(
        .MAX_RANK(MAX_RANK)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_beat     (i_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_beat     (o_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Keeps the k largest keys in offset binary, so an unsigned compare orders them as signed.
    task automatic track_value(input t_in_beat b);
        logic [VALUE_BITS-1:0] key;
        logic [VALUE_BITS-1:0] tmp;
        t_out_beat             res;
        int                    ke;
        int                    pos;
        int                    par;
        int                    lft;
        int                    ch;
        bit                    done;
        key  = b.value ^ SIGN_BIT;
        ke   = (rank_k == 0) ? 1 : ((rank_k > MAX_RANK) ? MAX_RANK : int'(rank_k));
        done = 1'b0;
        if (held_count < ke) begin
            heap_keys[held_count] = key;
            pos = held_count;
            while (pos > 0 && !done) begin
                par = (pos - 1) / 2;
                if (heap_keys[pos] < heap_keys[par]) begin
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[par];
                    heap_keys[par] = tmp;
                    pos = par;
                end else begin
                    done = 1'b1;
                end
            end
            held_count++;
        end else if (key > heap_keys[0]) begin
            heap_keys[0] = key;
            pos = 0;
            while (!done) begin
                lft = 2 * pos + 1;
                if (lft >= held_count) begin
                    done = 1'b1;
                end else begin
                    ch = lft;
                    if (lft + 1 < held_count && heap_keys[lft+1] < heap_keys[lft]) begin
                        ch = lft + 1;
                    end
                    if (heap_keys[ch] < heap_keys[pos]) begin
                        tmp = heap_keys[ch];
                        heap_keys[ch] = heap_keys[pos];
                        heap_keys[pos] = tmp;
                        pos = ch;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end
        if (b.last) begin
            res.kth_largest = heap_keys[0] ^ SIGN_BIT;
            res.enough      = (held_count >= ke);
            pending_ranks.push_front(res);
            held_count = 0;
        end
    endtask

    task automatic send_value(input logic [VALUE_BITS-1:0] value, input logic last);
        t_in_beat b;
        int       r;
        int       gap;
        b.value = value;
        b.last  = last;
        i_beat <= b;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        track_value(b);
        sent++;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_rank(input logic [K_BITS-1:0] k);
        start <= 1'b0;
        while (pending_ranks.size() > 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rank_k     = k;
        held_count = 0;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
            1:       return SIGN_BIT;
            2, 3:    return VALUE_BITS'($signed($urandom_range(0, 15)) - 8);
            4:       return VALUE_BITS'($urandom_range(0, 3) << 16);
            default: return VALUE_BITS'($urandom());
        endcase
    endfunction

    task automatic test_extremes_rank_one();
        set_rank(1);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0000_0000, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_short_set();
        set_rank(5);
        send_value(32'h0001_8000, 1'b0);
        send_value(32'hFFFE_0000, 1'b0);
        send_value(32'h0000_0001, 1'b1);
    endtask

    task automatic test_equal_values();
        set_rank(2);
        send_value(32'h0000_0007, 1'b0);
        send_value(32'h0000_0007, 1'b0);
        send_value(32'h0000_0007, 1'b1);
    endtask

    task automatic test_rank_out_of_range();
        set_rank(0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h1234_5678, 1'b1);
        set_rank(127);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0001, 1'b1);
    endtask

    task automatic test_rank_mid_set();
        set_rank(3);
        send_value(32'h7000_0000, 1'b0);
        send_value(32'h6000_0000, 1'b0);
        set_rank(2);
        send_value(32'hF000_0000, 1'b0);
        send_value(32'hE000_0000, 1'b0);
        send_value(32'h0000_0010, 1'b1);
    endtask

    task automatic run_phase(input logic [K_BITS-1:0] k);
        int ke;
        int sets;
        int size;
        int cut;
        set_rank(k);
        ke   = (k == 0) ? 1 : ((k > MAX_RANK) ? MAX_RANK : int'(k));
        sets = (ke > 16) ? 1 : 4;
        repeat (sets) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) size = $urandom_range(ke, 2 * ke + 2);
            else size = $urandom_range(1, ke);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, size) : 0;
            for (int i = 1; i <= size; i++) begin
                send_value(pick_value(), i == size);
                if (i == cut) set_rank(K_BITS'($urandom_range(1, 8)));
            end
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_sets();
        logic [K_BITS-1:0] plan [10] = '{2, 64, 1, 0, 127, 5, 3, 33, 100, 12};
        foreach (plan[i]) run_phase(plan[i]);
        while (sent < TARGET) begin
            if ($urandom_range(0, 4) != 0) run_phase(K_BITS'($urandom_range(1, 8)));
            else run_phase(K_BITS'($urandom_range(0, 127)));
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_out_beat want;
        if (i_rst_n && o_strobe) begin
            if (pending_ranks.size() == 0) begin
                $error("result beat with nothing pending: kth_largest %0d enough %0b",
                       o_beat.kth_largest, o_beat.enough);
                errors++;
            end else begin
                want = pending_ranks.pop_back();
                if (o_beat.kth_largest !== want.kth_largest) begin
                    $error("kth_largest: expected %0d, got %0d",
                           want.kth_largest, o_beat.kth_largest);
                    errors++;
                end
                if (o_beat.enough !== want.enough) begin
                    $error("enough: expected %0b, got %0b", want.enough, o_beat.enough);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= DOG_LIMIT) begin
            $display("tb_kth_largest_select: errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes_rank_one();
        test_short_set();
        test_equal_values();
        test_rank_out_of_range();
        test_rank_mid_set();
        test_random_sets();
        start <= 1'b0;
        while (pending_ranks.size() > 0) @(posedge i_clk);
        repeat (QUIET_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_ranks.size() == 0) begin
            $display("tb_kth_largest_select: clean");
        end else begin
            $display("tb_kth_largest_select: errors");
        end
        $finish;
    end

endmodule
